// File: rtl/core/hse_pkg.sv
// Shared types, constants and SHA-256 helper functions for the HMAC-SHA-256 engine.
// No dependencies; every other file of the block but hse_if imports this package.
`timescale 1ns / 1ps

package hse_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned CNT_W = 61;
	localparam logic [5:0] MAC_LEN_RESET = 6'd32;

	localparam logic [1:0] REQ_KEY = 2'd0;
	localparam logic [1:0] REQ_MSG = 2'd1;
	localparam logic [1:0] REQ_FIN = 2'd2;

	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;
	localparam logic [7:0] PAD_MARK = 8'h80;
	// length of the outer hash input in bits: one key block plus the inner digest
	localparam logic [63:0] OUTER_BITS = 64'd768;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		OP_KEY,
		OP_MSG,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef enum logic [1:0] {
		PH_KEYED,
		PH_KEYING,
		PH_MESSAGE
	} phase_t;

	typedef enum logic [1:0] {
		DST_WORK,
		DST_INNER,
		DST_OUTER
	} dest_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_KEY,
		ST_KEYWR,
		ST_KF,
		ST_KF_PAD1,
		ST_KF_PAD2,
		ST_KF_DIG,
		ST_KF_IN,
		ST_KF_OUT,
		ST_KF_END,
		ST_MSTART,
		ST_MSG,
		ST_MSGC,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_FIN4,
		ST_WAIT,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		unique case (i)
			6'd0: sha_k = 32'h428a2f98;   6'd1: sha_k = 32'h71374491;
			6'd2: sha_k = 32'hb5c0fbcf;   6'd3: sha_k = 32'he9b5dba5;
			6'd4: sha_k = 32'h3956c25b;   6'd5: sha_k = 32'h59f111f1;
			6'd6: sha_k = 32'h923f82a4;   6'd7: sha_k = 32'hab1c5ed5;
			6'd8: sha_k = 32'hd807aa98;   6'd9: sha_k = 32'h12835b01;
			6'd10: sha_k = 32'h243185be;  6'd11: sha_k = 32'h550c7dc3;
			6'd12: sha_k = 32'h72be5d74;  6'd13: sha_k = 32'h80deb1fe;
			6'd14: sha_k = 32'h9bdc06a7;  6'd15: sha_k = 32'hc19bf174;
			6'd16: sha_k = 32'he49b69c1;  6'd17: sha_k = 32'hefbe4786;
			6'd18: sha_k = 32'h0fc19dc6;  6'd19: sha_k = 32'h240ca1cc;
			6'd20: sha_k = 32'h2de92c6f;  6'd21: sha_k = 32'h4a7484aa;
			6'd22: sha_k = 32'h5cb0a9dc;  6'd23: sha_k = 32'h76f988da;
			6'd24: sha_k = 32'h983e5152;  6'd25: sha_k = 32'ha831c66d;
			6'd26: sha_k = 32'hb00327c8;  6'd27: sha_k = 32'hbf597fc7;
			6'd28: sha_k = 32'hc6e00bf3;  6'd29: sha_k = 32'hd5a79147;
			6'd30: sha_k = 32'h06ca6351;  6'd31: sha_k = 32'h14292967;
			6'd32: sha_k = 32'h27b70a85;  6'd33: sha_k = 32'h2e1b2138;
			6'd34: sha_k = 32'h4d2c6dfc;  6'd35: sha_k = 32'h53380d13;
			6'd36: sha_k = 32'h650a7354;  6'd37: sha_k = 32'h766a0abb;
			6'd38: sha_k = 32'h81c2c92e;  6'd39: sha_k = 32'h92722c85;
			6'd40: sha_k = 32'ha2bfe8a1;  6'd41: sha_k = 32'ha81a664b;
			6'd42: sha_k = 32'hc24b8b70;  6'd43: sha_k = 32'hc76c51a3;
			6'd44: sha_k = 32'hd192e819;  6'd45: sha_k = 32'hd6990624;
			6'd46: sha_k = 32'hf40e3585;  6'd47: sha_k = 32'h106aa070;
			6'd48: sha_k = 32'h19a4c116;  6'd49: sha_k = 32'h1e376c08;
			6'd50: sha_k = 32'h2748774c;  6'd51: sha_k = 32'h34b0bcb5;
			6'd52: sha_k = 32'h391c0cb3;  6'd53: sha_k = 32'h4ed8aa4a;
			6'd54: sha_k = 32'h5b9cca4f;  6'd55: sha_k = 32'h682e6ff3;
			6'd56: sha_k = 32'h748f82ee;  6'd57: sha_k = 32'h78a5636f;
			6'd58: sha_k = 32'h84c87814;  6'd59: sha_k = 32'h8cc70208;
			6'd60: sha_k = 32'h90befffa;  6'd61: sha_k = 32'ha4506ceb;
			6'd62: sha_k = 32'hbef9a3f7;  6'd63: sha_k = 32'hc67178f2;
			default: sha_k = 32'h0;
		endcase
	endfunction

	// Pad a partial block: keep bytes below pos, mark at pos, zero the rest,
	// and put the bit length in the tail when it still fits.
	function automatic logic [511:0] pad_block(input logic [511:0] buf_in,
			input logic [5:0] pos, input logic [63:0] bits);
		logic [511:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (i < int'(pos))
				r[511-8*i -: 8] = buf_in[511-8*i -: 8];
			else if (i == int'(pos))
				r[511-8*i -: 8] = PAD_MARK;
		end
		if (pos < 6'd56)
			r[63:0] = bits;
		pad_block = r;
	endfunction

	function automatic logic [511:0] xor_pad(input logic [511:0] k, input logic [7:0] p);
		logic [511:0] r;
		for (int i = 0; i < 64; i++)
			r[8*i +: 8] = k[8*i +: 8] ^ p;
		xor_pad = r;
	endfunction

endpackage

// File: rtl/core/hse_if.sv
// Valid/ready channel interfaces for request items and MAC byte items.
// Depends on nothing.
`timescale 1ns / 1ps

interface hse_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface hse_mac_if;
	logic       valid;
	logic       ready;
	logic [7:0] mac_byte;
	logic       last_byte;

	modport source (output valid, output mac_byte, output last_byte, input ready);
	modport sink (input valid, input mac_byte, input last_byte, output ready);
endinterface

// File: rtl/core/hse_front.sv
// Front end: accepts request items, classifies them and queues them for the sequencer.
// Depends on hse_pkg and hse_req_if.
`timescale 1ns / 1ps

module hse_front import hse_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	hse_req_if.sink      req,
	output queue_head_t  head,
	input  logic         pop
);
	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	item_t           mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            accept, push, do_pop;
	item_t           cls;

	assign req.ready = (count_q != CntW'(QueueDepth));
	assign accept    = req.valid && req.ready;

	// classify; an unused request code is accepted and dropped here
	always_comb begin
		cls.data = req.data_byte;
		push     = accept;
		unique case (req.req_type)
			REQ_KEY: cls.op = OP_KEY;
			REQ_MSG: cls.op = OP_MSG;
			REQ_FIN: cls.op = OP_FIN;
			default: begin
				cls.op = OP_FIN;
				push   = 1'b0;
			end
		endcase
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/hse_compress.sv
// SHA-256 compression unit: one round per cycle, 64 rounds plus a final chain add.
// Depends on hse_pkg.
`timescale 1ns / 1ps

module hse_compress import hse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] chain_in,
	input  logic [511:0] block_in,
	output logic         done,
	output logic [255:0] chain_out
);
	logic [255:0] h_q, v_q;
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic         busy_q, done_q;
	logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, w_new;

	assign {a, b, c, d, e, f, g, hh} = v_q;

	always_comb begin
		t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
			+ sha_k(rnd_q) + w_q[0];
		t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		w_new = (ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
			+ (ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
	end

	always_comb begin
		for (int i = 0; i < 8; i++)
			chain_out[255-32*i -: 32] = h_q[255-32*i -: 32] + v_q[255-32*i -: 32];
	end
	assign done = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= chain_in;
			v_q <= chain_in;
			for (int i = 0; i < 16; i++)
				w_q[i] <= block_in[511-32*i -: 32];
		end else if (busy_q) begin
			v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/hse_back.sv
// Back end: sequencer that carries out queued items, holds key, chains and buffers,
// and drives the MAC byte output register. Depends on hse_pkg, hse_if, hse_compress.
`timescale 1ns / 1ps

module hse_back import hse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  queue_head_t  head,
	output logic         pop,
	input  logic [5:0]   mac_length,
	hse_mac_if.source    mac
);
	state_t          state_q, state_d, ret_q, ret_d;
	dest_t           dest_q, dest_d;
	phase_t          phase_q;
	item_t           item_q;
	logic            init_q;
	logic [511:0]    key_q, blk_q;
	logic [CNT_W-1:0] key_len_q, cnt_q, cnt_inc, len_inc;
	logic [255:0]    work_q, inner_q, outer_q, mac_q;
	logic [4:0]      emit_q, nlast_q, nlast_d;
	logic            ovalid_q, olast_q, oload;
	logic [7:0]      obyte_q;
	logic            c_start, c_done;
	logic [255:0]    c_chain, c_out;
	logic [511:0]    c_block;
	logic [63:0]     key_bits, msg_bits;

	hse_compress u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (c_start),
		.chain_in  (c_chain),
		.block_in  (c_block),
		.done      (c_done),
		.chain_out (c_out)
	);

	assign cnt_inc  = cnt_q + 1'b1;
	assign len_inc  = key_len_q + 1'b1;
	assign key_bits = {key_len_q, 3'b000};
	assign msg_bits = {cnt_q + CNT_W'(64), 3'b000};

	assign oload        = (state_q == ST_EMIT) && (!ovalid_q || mac.ready);
	assign mac.valid     = ovalid_q;
	assign mac.mac_byte  = obyte_q;
	assign mac.last_byte = olast_q;

	always_comb begin
		if (mac_length == 6'd0)
			nlast_d = 5'd0;
		else if (mac_length > 6'd32)
			nlast_d = 5'd31;
		else
			nlast_d = 5'(mac_length - 6'd1);
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		dest_d  = dest_q;
		pop     = 1'b0;
		c_start = 1'b0;
		c_chain = work_q;
		c_block = key_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (head.item.op)
						OP_KEY: state_d = ST_KEY;
						default: begin
							if (phase_q == PH_KEYING)
								state_d = ST_KF;
							else if (phase_q == PH_MESSAGE && head.item.op == OP_MSG)
								state_d = ST_MSG;
							else
								state_d = ST_MSTART;
						end
					endcase
				end
			end
			ST_KEY: begin
				if (phase_q != PH_KEYING)
					state_d = ST_IDLE;
				else if (key_len_q >= CNT_W'(64) && key_len_q[5:0] == 6'd0) begin
					c_start = 1'b1;
					dest_d  = DST_WORK;
					ret_d   = ST_KEYWR;
					state_d = ST_WAIT;
				end else
					state_d = ST_KEYWR;
			end
			ST_KEYWR: state_d = ST_IDLE;
			ST_KF: begin
				if (key_len_q > CNT_W'(64)) begin
					if (key_len_q[5:0] == 6'd0) begin
						c_start = 1'b1;
						dest_d  = DST_WORK;
						ret_d   = ST_KF_PAD1;
						state_d = ST_WAIT;
					end else
						state_d = ST_KF_PAD1;
				end else
					state_d = ST_KF_IN;
			end
			ST_KF_PAD1: begin
				c_start = 1'b1;
				c_block = pad_block(key_q, key_len_q[5:0], key_bits);
				dest_d  = DST_WORK;
				ret_d   = (key_len_q[5:0] >= 6'd56) ? ST_KF_PAD2 : ST_KF_DIG;
				state_d = ST_WAIT;
			end
			ST_KF_PAD2: begin
				c_start = 1'b1;
				c_block = {448'd0, key_bits};
				dest_d  = DST_WORK;
				ret_d   = ST_KF_DIG;
				state_d = ST_WAIT;
			end
			ST_KF_DIG: state_d = ST_KF_IN;
			ST_KF_IN: begin
				c_start = 1'b1;
				c_chain = SHA_IV;
				c_block = xor_pad(key_q, IPAD);
				dest_d  = DST_INNER;
				ret_d   = ST_KF_OUT;
				state_d = ST_WAIT;
			end
			ST_KF_OUT: begin
				c_start = 1'b1;
				c_chain = SHA_IV;
				c_block = xor_pad(key_q, OPAD);
				dest_d  = DST_OUTER;
				ret_d   = ST_KF_END;
				state_d = ST_WAIT;
			end
			ST_KF_END: state_d = init_q ? ST_IDLE : ST_MSTART;
			ST_MSTART: state_d = (item_q.op == OP_MSG) ? ST_MSG : ST_FIN1;
			ST_MSG: state_d = (cnt_inc[5:0] == 6'd0) ? ST_MSGC : ST_IDLE;
			ST_MSGC: begin
				c_start = 1'b1;
				c_block = blk_q;
				dest_d  = DST_WORK;
				ret_d   = ST_IDLE;
				state_d = ST_WAIT;
			end
			ST_FIN1: begin
				c_start = 1'b1;
				c_block = pad_block(blk_q, cnt_q[5:0], msg_bits);
				dest_d  = DST_WORK;
				ret_d   = (cnt_q[5:0] >= 6'd56) ? ST_FIN2 : ST_FIN3;
				state_d = ST_WAIT;
			end
			ST_FIN2: begin
				c_start = 1'b1;
				c_block = {448'd0, msg_bits};
				dest_d  = DST_WORK;
				ret_d   = ST_FIN3;
				state_d = ST_WAIT;
			end
			ST_FIN3: begin
				c_start = 1'b1;
				c_chain = outer_q;
				c_block = {work_q, PAD_MARK, 184'd0, OUTER_BITS};
				dest_d  = DST_WORK;
				ret_d   = ST_FIN4;
				state_d = ST_WAIT;
			end
			ST_FIN4: state_d = ST_EMIT;
			ST_WAIT: if (c_done) state_d = ret_q;
			ST_EMIT: if (oload && emit_q == nlast_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KF_IN;
			ret_q   <= ST_IDLE;
			dest_q  <= DST_WORK;
			init_q  <= 1'b1;
			phase_q <= PH_KEYED;
			key_q   <= '0;
			key_len_q <= '0;
			cnt_q   <= '0;
			work_q  <= SHA_IV;
			ovalid_q <= 1'b0;
			emit_q  <= '0;
			nlast_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			dest_q  <= dest_d;
			if (mac.ready)
				ovalid_q <= 1'b0;
			if (oload) begin
				ovalid_q <= 1'b1;
				emit_q   <= emit_q + 1'b1;
			end
			unique case (state_q)
				ST_KEY: begin
					if (phase_q != PH_KEYING) begin
						key_q     <= {item_q.data, 504'd0};
						key_len_q <= CNT_W'(1);
						work_q    <= SHA_IV;
						phase_q   <= PH_KEYING;
					end
				end
				ST_KEYWR: begin
					key_q[511-8*key_len_q[5:0] -: 8] <= item_q.data;
					key_len_q <= len_inc;
				end
				ST_KF_DIG: key_q <= {work_q, 256'd0};
				ST_KF_END: begin
					phase_q <= PH_KEYED;
					init_q  <= 1'b0;
				end
				ST_MSTART: begin
					if (phase_q != PH_MESSAGE) begin
						work_q  <= inner_q;
						cnt_q   <= '0;
						phase_q <= PH_MESSAGE;
					end
				end
				ST_MSG: cnt_q <= cnt_inc;
				ST_FIN4: begin
					work_q  <= inner_q;
					cnt_q   <= '0;
					phase_q <= PH_KEYED;
					emit_q  <= '0;
					nlast_q <= nlast_d;
				end
				ST_WAIT: begin
					if (c_done && dest_q == DST_WORK)
						work_q <= c_out;
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (pop)
			item_q <= head.item;
		if (state_q == ST_MSG)
			blk_q[511-8*cnt_q[5:0] -: 8] <= item_q.data;
		if (state_q == ST_WAIT && c_done && dest_q == DST_INNER)
			inner_q <= c_out;
		if (state_q == ST_WAIT && c_done && dest_q == DST_OUTER)
			outer_q <= c_out;
		if (state_q == ST_FIN4)
			mac_q <= work_q;
		if (oload) begin
			obyte_q <= mac_q[255-8*emit_q -: 8];
			olast_q <= (emit_q == nlast_q);
		end
	end

endmodule

// File: rtl/core/hmac_sha256_engine.sv
// Top level of the byte-stream HMAC-SHA-256 engine.
// Depends on hse_pkg, hse_if, hse_front, hse_back (and hse_compress below it).
`timescale 1ns / 1ps

// Usage:
//  req channel (valid/ready): one item per byte. req_type 0 is a key byte,
//  1 a message byte, 2 finishes the message; code 3 is taken and dropped.
//  mac channel (valid/ready): the leading mac_length bytes of the tag, most
//  significant first, last_byte high on the final one.
//  cfg_we/cfg_wdata write mac_length (0 acts as 1, above 32 as 32); write it
//  only while the engine is idle.
//  Flow: a small queue decouples intake from the sequencer, so items are
//  taken while the sequencer computes. Every 64th message byte adds one
//  compression (64 rounds of the single round unit, plus start and chain
//  add). A finish costs two or three compressions before the first tag
//  byte; the first item after new key bytes adds two to four more
//  compressions. Reset: computes the keyed chains of the empty key; items
//  queue meanwhile. A stalled mac receiver holds the output register and
//  the sequencer; the queue keeps accepting until it is full.
module hmac_sha256_engine import hse_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hse_req_if.sink    req,
	hse_mac_if.source  mac,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);
	queue_head_t head;
	logic        pop;
	logic [5:0]  mac_length_q;

	// tag truncation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mac_length_q <= MAC_LEN_RESET;
		else if (cfg_we)
			mac_length_q <= cfg_wdata;
	end

	// intake and classify
	hse_front #(
		.QueueDepth (QueueDepth)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	// execute items and emit tag bytes
	hse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.mac_length (mac_length_q),
		.mac        (mac)
	);

endmodule

// File: verif/hmac_sha256_engine_test.sv
// Self-checking bench for the byte-stream HMAC-SHA-256 engine: random and directed
// key, message and finish items are predicted by a local SHA-256/HMAC model.
// Depends on hse_pkg, hse_if and the engine RTL.
`timescale 1ns / 1ps

module hmac_sha256_engine_test;
	import hse_pkg::*;

	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int unsigned TAIL_CYCLES = 400;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} req_item_t;

	typedef struct packed {
		logic [7:0] mac_byte;
		logic       last_byte;
	} mac_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [5:0] cfg_wdata;

	hse_req_if req_ch();
	hse_mac_if mac_ch();

	hmac_sha256_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.mac       (mac_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Clock: 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Pending request items and expected tag bytes
	req_item_t pending_reqs[$];
	mac_item_t tag_bytes_due[$];
	int unsigned fail_count;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit req_taken;

	// ---- predictor state (a private copy of what the engine holds) ----
	logic [5:0]    tag_len;
	logic [7:0]    key_bytes[64];
	logic [60:0]   key_count;
	logic [31:0]   run_chain[8];
	logic [31:0]   ipad_chain[8];
	logic [31:0]   opad_chain[8];
	logic [7:0]    msg_block[64];
	logic [60:0]   msg_count;
	phase_t        mode;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one SHA-256 compression of a 64-byte block into chain h
	task automatic sha_block(ref logic [31:0] h[8], input logic [7:0] b[64]);
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2;
		logic [31:0] kc[64];
		kc = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,
			32'h59f111f1,32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,
			32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,
			32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
			32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,
			32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
			32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
			32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,32'hd192e819,
			32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,32'h1e376c08,
			32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,
			32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		for (int i = 0; i < 16; i++)
			w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		v = h;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			h[i] = h[i] + v[i];
	endtask

	// pad the pending bytes, run the last block(s), return the digest bytes
	task automatic sha_close(ref logic [31:0] h[8], input logic [7:0] b[64],
			input int pos, input logic [63:0] bits, output logic [7:0] dig[32]);
		b[pos] = PAD_MARK;
		pos++;
		if (pos > 56) begin
			for (int i = pos; i < 64; i++) b[i] = 8'h00;
			sha_block(h, b);
			pos = 0;
		end
		for (int i = pos; i < 56; i++) b[i] = 8'h00;
		for (int i = 0; i < 8; i++) b[56+i] = bits[63-8*i -: 8];
		sha_block(h, b);
		for (int i = 0; i < 32; i++) dig[i] = h[i/4][31-8*(i%4) -: 8];
	endtask

	task automatic load_iv(ref logic [31:0] h[8]);
		for (int i = 0; i < 8; i++) h[i] = SHA_IV[255-32*i -: 32];
	endtask

	// finish the key: shrink long keys, then derive the inner and outer chains
	task automatic settle_key();
		logic [7:0] pad[64];
		logic [7:0] dig[32];
		if (key_count > 61'd64) begin
			if (key_count[5:0] == 6'd0) sha_block(run_chain, key_bytes);
			sha_close(run_chain, key_bytes, int'(key_count[5:0]), {key_count, 3'b000}, dig);
			for (int i = 0; i < 64; i++) key_bytes[i] = (i < 32) ? dig[i] : 8'h00;
		end
		for (int i = 0; i < 64; i++) pad[i] = key_bytes[i] ^ IPAD;
		load_iv(ipad_chain);
		sha_block(ipad_chain, pad);
		for (int i = 0; i < 64; i++) pad[i] = key_bytes[i] ^ OPAD;
		load_iv(opad_chain);
		sha_block(opad_chain, pad);
		mode = PH_KEYED;
	endtask

	task automatic open_message();
		if (mode == PH_KEYING) settle_key();
		if (mode != PH_MESSAGE) begin
			run_chain = ipad_chain;
			msg_count = '0;
			mode = PH_MESSAGE;
		end
	endtask

	task automatic predictor_reset();
		tag_len = MAC_LEN_RESET;
		for (int i = 0; i < 64; i++) key_bytes[i] = 8'h00;
		key_count = '0;
		msg_count = '0;
		settle_key();
		load_iv(run_chain);
		mode = PH_KEYED;
	endtask

	// advance the predictor by one accepted item; push any tag bytes it yields
	task automatic predict_tag(input req_item_t it);
		logic [7:0] inner[32];
		logic [7:0] tag[32];
		logic [7:0] outer_blk[64];
		logic [31:0] h[8];
		int n;
		case (it.kind)
			REQ_KEY: begin
				if (mode != PH_KEYING) begin
					for (int i = 0; i < 64; i++) key_bytes[i] = 8'h00;
					key_count = '0;
					load_iv(run_chain);
					mode = PH_KEYING;
				end
				if (key_count >= 61'd64 && key_count[5:0] == 6'd0)
					sha_block(run_chain, key_bytes);
				key_bytes[key_count[5:0]] = it.data;
				key_count = key_count + 61'd1;
			end
			REQ_MSG: begin
				open_message();
				msg_block[msg_count[5:0]] = it.data;
				msg_count = msg_count + 61'd1;
				if (msg_count[5:0] == 6'd0) sha_block(run_chain, msg_block);
			end
			REQ_FIN: begin
				open_message();
				sha_close(run_chain, msg_block, int'(msg_count[5:0]),
					{msg_count + 61'd64, 3'b000}, inner);
				h = opad_chain;
				for (int i = 0; i < 64; i++) outer_blk[i] = (i < 32) ? inner[i] : 8'h00;
				sha_close(h, outer_blk, 32, OUTER_BITS, tag);
				run_chain = ipad_chain;
				msg_count = '0;
				mode = PH_KEYED;
				n = (tag_len < 6'd1) ? 1 : (tag_len > 6'd32) ? 32 : int'(tag_len);
				for (int k = 0; k < n; k++)
					tag_bytes_due.push_back('{mac_byte: tag[k], last_byte: (k + 1 == n)});
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		fail_count++;
	endtask

	// ---- driver: present the next pending item at the falling edge ----
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_taken) begin
			// hold the item until it is taken
		end else if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
			req_ch.valid     <= 1'b1;
			req_ch.req_type  <= pending_reqs[0].kind;
			req_ch.data_byte <= pending_reqs[0].data;
			void'(pending_reqs.pop_front());
		end else begin
			req_ch.valid <= 1'b0;
		end
		mac_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// ---- monitor: predict on each accepted item, check each tag byte ----
	always @(posedge clk) begin
		mac_item_t got;
		mac_item_t want;
		bit moved;
		moved = 1'b0;
		req_taken <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				moved = 1'b1;
				predict_tag('{kind: req_ch.req_type, data: req_ch.data_byte});
			end
			if (mac_ch.valid && mac_ch.ready) begin
				moved = 1'b1;
				got = '{mac_byte: mac_ch.mac_byte, last_byte: mac_ch.last_byte};
				if (tag_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected tag byte %02h", got.mac_byte));
				end else begin
					want = tag_bytes_due.pop_front();
					if (got.mac_byte !== want.mac_byte)
						report_mismatch($sformatf("mac_byte %02h, want %02h",
							got.mac_byte, want.mac_byte));
					if (got.last_byte !== want.last_byte)
						report_mismatch($sformatf("last_byte %0b, want %0b",
							got.last_byte, want.last_byte));
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic [1:0] kind, input logic [7:0] data);
		pending_reqs.push_back('{kind: kind, data: data});
	endtask

	// wait for the driver to drain its queue and the engine to return every byte
	task automatic drain();
		while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);
		@(posedge clk);
		while (tag_bytes_due.size() > 0) @(posedge clk);
		// let trailing key or message work settle before touching the register
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_tag_len(input logic [5:0] len);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tag_len = len;
	endtask

	// a well-formed run: optional new key, a message of random length, finish
	task automatic queue_session(input int max_key, input int max_msg);
		int klen;
		int mlen;
		if ($urandom_range(2, 0) == 0) begin
			klen = $urandom_range(max_key, 1);
			for (int i = 0; i < klen; i++) queue_item(REQ_KEY, 8'($urandom));
		end
		mlen = $urandom_range(max_msg, 0);
		for (int i = 0; i < mlen; i++) queue_item(REQ_MSG, 8'($urandom));
		if ($urandom_range(9, 0) == 0) queue_item(2'd3, 8'($urandom));
		queue_item(REQ_FIN, 8'($urandom));
	endtask

	task automatic random_phase(input int items, input int idle_pct, input int stall_pct);
		int start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = pending_reqs.size();
		while (pending_reqs.size() - start < items) begin
			if ($urandom_range(9, 0) == 0)
				queue_item(2'($urandom), 8'($urandom));
			else
				queue_session(($urandom_range(7, 0) == 0) ? 80 : 20, 12);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_KEY;
		req_ch.data_byte = '0;
		mac_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		quiet_cycles = 0;
		predictor_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: finish on the empty key and empty message, full tag; then a dropped code 3 and a two-byte message
		queue_item(REQ_FIN, 8'hff);
		queue_item(2'd3, 8'hff);
		queue_item(REQ_MSG, 8'h00);
		queue_item(REQ_MSG, 8'hff);
		queue_item(REQ_FIN, 8'h00);
		drain();
		// register extremes: zero acts as one, above 32 acts as 32
		write_tag_len(6'd0);
		for (int i = 0; i < 3; i++) queue_item(REQ_KEY, 8'hff);
		queue_item(REQ_FIN, 8'h00);
		drain();
		write_tag_len(6'd63);
		// a key of exactly 64 bytes, then one of 65 (hashed down)
		for (int i = 0; i < 64; i++) queue_item(REQ_KEY, 8'(i));
		queue_item(REQ_FIN, 8'h00);
		for (int i = 0; i < 65; i++) queue_item(REQ_KEY, 8'hff - 8'(i));
		queue_item(REQ_MSG, 8'h5a);
		queue_item(REQ_FIN, 8'h00);
		// a key of 128 bytes, a message of 56 bytes (padding spills a block)
		for (int i = 0; i < 128; i++) queue_item(REQ_KEY, 8'($urandom));
		for (int i = 0; i < 56; i++) queue_item(REQ_MSG, 8'($urandom));
		queue_item(REQ_FIN, 8'h00);
		// a partial message dropped by a new key
		for (int i = 0; i < 5; i++) queue_item(REQ_MSG, 8'($urandom));
		queue_item(REQ_KEY, 8'h80);
		queue_item(REQ_FIN, 8'h00);
		drain();
		write_tag_len(6'd1);

		random_phase(10, 0, 0);
		write_tag_len(6'd32);
		random_phase(10, 83, 0);
		write_tag_len(6'($urandom_range(31, 2)));
		random_phase(10, 0, 83);
		write_tag_len(6'd33);
		random_phase(10, 35, 35);

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: hmac_sha256_engine.f
rtl/core/hse_pkg.sv
rtl/core/hse_if.sv
rtl/core/hse_front.sv
rtl/core/hse_compress.sv
rtl/core/hse_back.sv
rtl/core/hmac_sha256_engine.sv
verif/hmac_sha256_engine_test.sv
